[rtl/assert_macros.svh]
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/bspd_pkg.sv]
// Types, register codes and reset values for the button press detector.
package bspd_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_EN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_EN    = 3'd5;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE_MS = 16'd50;
    localparam logic [CFG_W-1:0] RST_SHORT_MS    = 16'd50;
    localparam logic [CFG_W-1:0] RST_LONG_MS     = 16'd1000;
    localparam logic [CFG_W-1:0] RST_KEY_MASK    = 16'd1;

    localparam logic MODE_POLL = 1'b0;
    localparam logic MODE_EDGE = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] short_press_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] key_pin_mask;
        logic             short_event_enable;
        logic             long_event_enable;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] now_ms;
        logic [CFG_W-1:0]  pin_mask;
        logic              pin_level;
    } t_item;

    typedef struct packed {
        logic key_down;
        logic long_press;
        logic short_press;
    } t_result;

endpackage

[rtl/bspd_cfg_regs.sv]
// Configuration register file of the button press detector.
module bspd_cfg_regs import bspd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [CFG_W-1:0]     i_wr_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                CFG_DEBOUNCE: n_cfg.debounce_ms        = i_wr_data;
                CFG_SHORT_MS: n_cfg.short_press_ms     = i_wr_data;
                CFG_LONG_MS:  n_cfg.long_press_ms      = i_wr_data;
                CFG_KEY_MASK: n_cfg.key_pin_mask       = i_wr_data;
                CFG_SHORT_EN: n_cfg.short_event_enable = i_wr_data[0];
                CFG_LONG_EN:  n_cfg.long_event_enable  = i_wr_data[0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= RST_DEBOUNCE_MS;
            r_cfg.short_press_ms     <= RST_SHORT_MS;
            r_cfg.long_press_ms      <= RST_LONG_MS;
            r_cfg.key_pin_mask       <= RST_KEY_MASK;
            r_cfg.short_event_enable <= 1'b0;
            r_cfg.long_event_enable  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/bspd_eval.sv]
// Press state and per-item evaluation of the button press detector.
module bspd_eval import bspd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [TIME_W-1:0] r_press_start;
    logic [TIME_W-1:0] r_last_edge;
    logic              r_pressed;
    logic              r_long_fired;

    logic [TIME_W-1:0] n_press_start;
    logic [TIME_W-1:0] n_last_edge;
    logic              n_pressed;
    logic              n_long_fired;

    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_edge;
    logic              edge_ok;
    logic              short_hit;
    logic              long_hit;

    assign held       = i_item.now_ms - r_press_start;
    assign since_edge = i_item.now_ms - r_last_edge;
    assign edge_ok    = (i_item.mode == MODE_EDGE)
                     && (i_item.pin_mask == i_cfg.key_pin_mask)
                     && (since_edge >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_ms});

    always_comb begin
        n_press_start = r_press_start;
        n_last_edge   = r_last_edge;
        n_pressed     = r_pressed;
        n_long_fired  = r_long_fired;
        short_hit     = 1'b0;
        long_hit      = 1'b0;
        if (i_item.mode == MODE_POLL) begin
            // fire the long press once per press
            if (r_pressed && !r_long_fired
                && held >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms}) begin
                n_long_fired = 1'b1;
                long_hit     = i_cfg.long_event_enable;
            end
        end else if (edge_ok) begin
            n_last_edge = i_item.now_ms;
            if (!i_item.pin_level) begin
                n_pressed     = 1'b1;
                n_long_fired  = 1'b0;
                n_press_start = i_item.now_ms;
            end else begin
                short_hit = r_pressed && !r_long_fired && i_cfg.short_event_enable
                         && held >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.short_press_ms};
                n_pressed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_start <= '0;
            r_last_edge   <= '0;
            r_pressed     <= 1'b0;
            r_long_fired  <= 1'b0;
        end else if (i_adv) begin
            r_press_start <= n_press_start;
            r_last_edge   <= n_last_edge;
            r_pressed     <= n_pressed;
            r_long_fired  <= n_long_fired;
        end
    end

    assign o_result.short_press = short_hit;
    assign o_result.long_press  = long_hit;
    assign o_result.key_down    = n_pressed;

endmodule

[rtl/button_short_long_press_detector_unit.sv]
// Top level of the button short/long press detector.
//
// Input stream (s_axis): one transaction per poll or pin edge event. tuser
// carries the mode (0 poll, 1 edge); tdata carries the timestamp, pin mask
// and sampled level. Output stream (m_axis): exactly one result transaction
// per input transaction, in order, with short press, long press and the
// logical key state after the item.
// Configuration: write channel i_cfg_valid / o_cfg_ready with a register
// index and 16-bit data; ready is always high. Write only while idle.
// Pipeline: the input register takes the item, then the evaluation result
// is loaded into the output register once that slot is free.
// Throughput: one item per cycle while m_axis_tready stays high; the
// evaluation against the press state is combinational.
// Stall: when m_axis_tready is low, the output register holds its result and
// the input register holds one more item; after that s_axis_tready drops.
// Reset (synchronous, active low): clears both stage valids, the press state
// (released, no long press fired, timestamps zero) and restores register
// defaults: debounce 50, short 50, long 1000, key mask 1, events disabled.
`include "assert_macros.svh"

module button_short_long_press_detector_unit import bspd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,  // [31:0] now_ms, [47:32] pin_mask,
                                                // [48] pin_level, [55:49] zero
    input  logic [0:0]           s_axis_tuser,  // [0] mode
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [0] short_press, [1] long_press,
                                                // [2] key_down, [7:3] zero
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_vld;
    t_result r_out;
    logic    r_out_vld;
    t_result eval_res;
    logic    adv;
    logic    in_take;

    // configuration is always taken at once
    assign o_cfg_ready = 1'b1;

    bspd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // advance the held item into the output register when that slot frees
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    // payload: load on every accepted transaction, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.mode      <= s_axis_tuser[0];
            r_in.now_ms    <= s_axis_tdata[31:0];
            r_in.pin_mask  <= s_axis_tdata[47:32];
            r_in.pin_level <= s_axis_tdata[48];
        end
    end

    bspd_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (eval_res)
    );

    // output register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= eval_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b0, r_out.key_down, r_out.long_press, r_out.short_press};

    // a short press ends the press, so the key reads released
    `ASSERT_IMPL(a_short_released, r_out_vld && r_out.short_press, !r_out.key_down, "short, key down")
    // a long press fires only while the key is held
    `ASSERT_IMPL(a_long_pressed, r_out_vld && r_out.long_press, r_out.key_down, "long, key up")
    // one item never reports both events
    `ASSERT_ALWAYS(a_one_event, !(r_out_vld && r_out.short_press && r_out.long_press), "both set")
    // with both stages full and the receiver stalled, take no new item
    `ASSERT_IMPL(a_full_stall, r_in_vld && r_out_vld && !m_axis_tready, !s_axis_tready, "taken full")

endmodule
